// File: src/tgpm_pkg.sv
// Shared types, constants and the exponential lookup table of the tailed
// Gaussian peak model. No dependencies.
package tgpm_pkg;

    localparam int EXP_TABLE_DEPTH  = 256;
    localparam int EXP_IDX_W        = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_ROM_W        = 17;
    localparam int SIGMA_FACTOR_Q16 = 154325;
    localparam int LOG2E_Q16        = 94548;
    localparam int EXP_ARG_MIN      = -1572864;
    localparam int EXP_ARG_MAX      = 655360;
    localparam int U_LIMIT          = 1048576;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 34;
    localparam int DIV_SD_W = 80;
    localparam int QCNT_W  = 5;

    typedef logic [EXP_ROM_W-1:0] t_exp_rom [EXP_TABLE_DEPTH];

    // shift and subtract quotient, used only while building the table
    function automatic longint unsigned udiv_small(input longint unsigned num,
                                                   input longint unsigned dv);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[62:0], num[j]};
            if (r >= dv) begin
                r    = r - dv;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^(i/N) in Q.16 from a 16 term Q30 series
    function automatic t_exp_rom exp_rom_build();
        t_exp_rom rom;
        longint unsigned t;
        longint unsigned sum;
        longint unsigned term;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            t    = (longint'(i) * LN2_Q30) >> EXP_IDX_W;
            sum  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                term = udiv_small((term * t) >> 30, 64'(k));
                sum  = sum + term;
            end
            rom[i] = EXP_ROM_W'((sum + 64'd8192) >> 14);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = exp_rom_build();

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic                        start;
        t_alu_op                     op;
        logic signed [MUL_A_W-1:0]   a;
        logic signed [MUL_B_W-1:0]   b;
        logic [63:0]                 num;
        logic [63:0]                 den;
        logic [QCNT_W-1:0]           qbits;
    } t_alu_req;

endpackage

// File: src/tailed_gaussian_peak_model.sv
// Tailed Gaussian peak model: evaluates background plus per-beat sub-peak
// terms at a channel position, one beat at a time. An input beat inside the
// window takes two restoring divisions of 22 and 17 quotient bits plus eight
// passes through the shared multiplier, nine when it also starts the group and
// adds the background; a beat of a group that lies outside the window skips
// the arithmetic. All arithmetic goes through one tgpm_alu.
// s_axis_tready is high only between beats. A finished sum waits in the
// output register while the next beat is taken; a last beat stalls until that
// register is free. Uses tgpm_pkg, tgpm_alu, tgpm_exp.
module tailed_gaussian_peak_model (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // position, amplitude, centroid, width_fwhm, left_tail, right_tail, step_ratio
    input  logic [151:0] s_axis_tdata,
    // first_term
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // model_value
    output logic [47:0]  m_axis_tdata,
    // saturated
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] REG_WIN_LO   = 2'd0;
    localparam logic [1:0] REG_WIN_HI   = 2'd1;
    localparam logic [1:0] REG_BG_OFF   = 2'd2;
    localparam logic [1:0] REG_BG_SLOPE = 2'd3;

    typedef enum logic [17:0] {
        ST_IDLE = 18'd1,
        ST_BG0  = 18'd2,
        ST_BG1  = 18'd4,
        ST_U0   = 18'd8,
        ST_U1   = 18'd16,
        ST_U2   = 18'd32,
        ST_E0   = 18'd64,
        ST_E1   = 18'd128,
        ST_E2   = 18'd256,
        ST_P0   = 18'd512,
        ST_Q0   = 18'd1024,
        ST_Q1   = 18'd2048,
        ST_Q2   = 18'd4096,
        ST_Q3   = 18'd8192,
        ST_Q4   = 18'd16384,
        ST_Q5   = 18'd32768,
        ST_OUT  = 18'd65536,
        ST_WAIT = 18'd131072
    } t_state;

    logic [23:0]        r_win_lo, r_win_hi;
    logic signed [31:0] r_bg_off, r_bg_slope;

    logic [23:0]        r_pos, r_cen, r_w;
    logic signed [31:0] r_amp;
    logic signed [15:0] r_lam, r_rho, r_sr;
    logic               r_first, r_last;

    t_state             r_state, n_state, r_ret, n_ret;
    logic signed [47:0] r_sum, n_sum;
    logic               r_inside, n_inside, r_clip, n_clip;
    logic signed [21:0] r_u, n_u;
    logic               r_gauss, n_gauss;
    logic [31:0]        r_expv, n_expv;
    logic               r_ovalid, n_ovalid, r_osat, n_osat;
    logic [47:0]        r_oval, n_oval;

    tgpm_pkg::t_alu_req req;
    logic [63:0]        alu_res;
    logic               alu_done;
    logic [31:0]        exp_val;

    logic               accept;
    logic               cfg_wr;
    logic               in_win;
    logic signed [24:0] d;
    logic signed [24:0] mag_full;
    logic [23:0]        mag;
    logic [20:0]        qc;
    logic signed [21:0] u_pos, u_new;
    logic signed [21:0] lam_x, rho_x;
    logic signed [63:0] p, ex, u_sc;
    logic [32:0]        den1;
    logic               acc_en;
    logic signed [63:0] acc_in;
    logic signed [64:0] acc_s;
    logic signed [47:0] acc_out;
    logic               acc_ovf;

    function automatic logic signed [21:0] clamp_arg(input logic signed [63:0] v);
        logic signed [21:0] r;
        if (v < 64'(tgpm_pkg::EXP_ARG_MIN)) begin
            r = 22'(tgpm_pkg::EXP_ARG_MIN);
        end else if (v > 64'(tgpm_pkg::EXP_ARG_MAX)) begin
            r = 22'(tgpm_pkg::EXP_ARG_MAX);
        end else begin
            r = v[21:0];
        end
        return r;
    endfunction

    tgpm_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (alu_res),
        .o_done  (alu_done)
    );

    tgpm_exp u_exp (
        .i_prod (signed'(alu_res)),
        .o_val  (exp_val)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_WIN_LO:   prdata = {8'b0, r_win_lo};
            REG_WIN_HI:   prdata = {8'b0, r_win_hi};
            REG_BG_OFF:   prdata = r_bg_off;
            REG_BG_SLOPE: prdata = r_bg_slope;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lo   <= '0;
            r_win_hi   <= 24'hFFFFFF;
            r_bg_off   <= '0;
            r_bg_slope <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIN_LO:   r_win_lo   <= pwdata[23:0];
                REG_WIN_HI:   r_win_hi   <= pwdata[23:0];
                REG_BG_OFF:   r_bg_off   <= pwdata;
                REG_BG_SLOPE: r_bg_slope <= pwdata;
                default:      r_win_lo   <= r_win_lo;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos   <= s_axis_tdata[23:0];
            r_amp   <= s_axis_tdata[55:24];
            r_cen   <= s_axis_tdata[79:56];
            r_w     <= (s_axis_tdata[103:80] == '0) ? 24'd1 : s_axis_tdata[103:80];
            r_lam   <= s_axis_tdata[119:104];
            r_rho   <= s_axis_tdata[135:120];
            r_sr    <= s_axis_tdata[151:136];
            r_first <= s_axis_tuser;
            r_last  <= s_axis_tlast;
        end
    end

    // datapath helpers
    always_comb begin
        in_win   = (r_pos >= r_win_lo) && (r_pos <= r_win_hi);
        d        = signed'({1'b0, r_pos}) - signed'({1'b0, r_cen});
        mag_full = d[24] ? -d : d;
        mag      = mag_full[23:0];
        qc       = (alu_res > 64'(tgpm_pkg::U_LIMIT)) ? 21'(tgpm_pkg::U_LIMIT)
                                                      : alu_res[20:0];
        u_pos    = signed'({1'b0, qc});
        u_new    = d[24] ? -u_pos : u_pos;
        lam_x    = 22'(r_lam);
        rho_x    = 22'(r_rho);
        p        = signed'(alu_res);
        ex       = r_gauss ? ((-p) >>> 1) : (p >>> 1);
        u_sc     = 64'(r_u) <<< 8;
        den1     = {1'b0, r_expv} + 33'd65536;
        acc_s    = 65'(r_sum) + 65'(acc_in);
        acc_ovf  = (acc_s[64:47] != {18{acc_s[64]}});
        if (!acc_ovf) begin
            acc_out = acc_s[47:0];
        end else if (acc_s[64]) begin
            acc_out = {1'b1, 47'b0};
        end else begin
            acc_out = {1'b0, {47{1'b1}}};
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_sum    = r_sum;
        n_inside = r_inside;
        n_clip   = r_clip;
        n_u      = r_u;
        n_gauss  = r_gauss;
        n_expv   = r_expv;
        n_ovalid = r_ovalid & ~m_axis_tready;
        n_oval   = r_oval;
        n_osat   = r_osat;
        acc_en   = 1'b0;
        acc_in   = '0;
        req.start = 1'b0;
        req.op    = tgpm_pkg::ALU_MUL;
        req.a     = '0;
        req.b     = '0;
        req.num   = '0;
        req.den   = '0;
        req.qbits = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_BG0;
                end
            end
            ST_BG0: begin
                if (r_first) begin
                    n_inside = in_win;
                    n_clip   = 1'b0;
                    n_sum    = in_win ? 48'(r_bg_off) : '0;
                    if (in_win) begin
                        req.start = 1'b1;
                        req.a     = 34'(r_bg_slope);
                        req.b     = 34'(signed'({1'b0, r_pos - r_win_lo}));
                        n_ret     = ST_BG1;
                        n_state   = ST_WAIT;
                    end else begin
                        n_state = ST_OUT;
                    end
                end else begin
                    n_state = r_inside ? ST_U0 : ST_OUT;
                end
            end
            ST_BG1: begin
                acc_en  = 1'b1;
                acc_in  = signed'(alu_res) >>> 16;
                n_state = ST_U0;
            end
            ST_U0: begin
                req.start = 1'b1;
                req.a     = signed'({10'b0, mag});
                req.b     = 34'(tgpm_pkg::SIGMA_FACTOR_Q16);
                n_ret     = ST_U1;
                n_state   = ST_WAIT;
            end
            ST_U1: begin
                req.start = 1'b1;
                req.op    = tgpm_pkg::ALU_DIV;
                req.num   = alu_res + (64'(r_w) << 7);
                req.den   = 64'(r_w) << 8;
                req.qbits = 5'd22;
                n_ret     = ST_U2;
                n_state   = ST_WAIT;
            end
            ST_U2: begin
                n_u       = u_new;
                req.start = 1'b1;
                if (u_new < lam_x) begin
                    n_gauss = 1'b0;
                    req.a   = 34'(r_lam);
                    req.b   = 34'(24'(r_lam) - (24'(u_new) <<< 1));
                end else if (u_new > rho_x) begin
                    n_gauss = 1'b0;
                    req.a   = 34'(r_rho);
                    req.b   = 34'(24'(r_rho) - (24'(u_new) <<< 1));
                end else begin
                    n_gauss = 1'b1;
                    req.a   = 34'(u_new);
                    req.b   = 34'(u_new);
                end
                n_ret   = ST_E0;
                n_state = ST_WAIT;
            end
            ST_E0: begin
                req.start = 1'b1;
                req.a     = 34'(clamp_arg(ex));
                req.b     = 34'(tgpm_pkg::LOG2E_Q16);
                n_ret     = ST_E1;
                n_state   = ST_WAIT;
            end
            ST_E1: begin
                n_expv  = exp_val;
                n_state = ST_E2;
            end
            ST_E2: begin
                req.start = 1'b1;
                req.a     = 34'(r_amp);
                req.b     = signed'({2'b0, r_expv});
                n_ret     = ST_P0;
                n_state   = ST_WAIT;
            end
            ST_P0: begin
                acc_en    = 1'b1;
                acc_in    = signed'(alu_res) >>> 16;
                req.start = 1'b1;
                req.a     = 34'(clamp_arg(u_sc));
                req.b     = 34'(tgpm_pkg::LOG2E_Q16);
                n_ret     = ST_Q0;
                n_state   = ST_WAIT;
            end
            ST_Q0: begin
                n_expv  = exp_val;
                n_state = ST_Q1;
            end
            ST_Q1: begin
                req.start = 1'b1;
                req.a     = signed'({1'b0, den1});
                req.b     = signed'({1'b0, den1});
                n_ret     = ST_Q2;
                n_state   = ST_WAIT;
            end
            ST_Q2: begin
                req.start = 1'b1;
                req.op    = tgpm_pkg::ALU_DIV;
                req.num   = (64'd1 << 48) + (alu_res >> 1);
                req.den   = alu_res;
                req.qbits = 5'd17;
                n_ret     = ST_Q3;
                n_state   = ST_WAIT;
            end
            ST_Q3: begin
                // step ratio times step factor fits in 32 signed bits
                req.start = 1'b1;
                req.a     = 34'(r_sr);
                req.b     = signed'({17'b0, alu_res[16:0]});
                n_ret     = ST_Q4;
                n_state   = ST_WAIT;
            end
            ST_Q4: begin
                req.start = 1'b1;
                req.a     = 34'(r_amp);
                req.b     = signed'(alu_res[33:0]);
                n_ret     = ST_Q5;
                n_state   = ST_WAIT;
            end
            ST_Q5: begin
                acc_en  = 1'b1;
                acc_in  = signed'(alu_res) >>> 24;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_inside ? r_sum : '0;
                    n_osat   = r_clip;
                    n_state  = ST_IDLE;
                end
            end
            ST_WAIT: begin
                if (alu_done) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (acc_en) begin
            n_sum  = acc_out;
            n_clip = r_clip | acc_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_sum    <= '0;
            r_inside <= 1'b0;
            r_clip   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_sum    <= n_sum;
            r_inside <= n_inside;
            r_clip   <= n_clip;
            r_ovalid <= n_ovalid;
        end
        r_u     <= n_u;
        r_gauss <= n_gauss;
        r_expv  <= n_expv;
        r_oval  <= n_oval;
        r_osat  <= n_osat;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_osat;

endmodule

// File: src/tgpm_alu.sv
// Shared arithmetic unit: registered signed multiplier and a restoring
// divider that yields one quotient bit per cycle. Uses tgpm_pkg.
module tgpm_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tgpm_pkg::t_alu_req  i_req,
    output logic [63:0]         o_res,
    output logic                o_done
);

    logic [63:0]                       r_res, n_res;
    logic [63:0]                       r_rem, n_rem;
    logic [tgpm_pkg::DIV_SD_W-1:0]     r_sd, n_sd;
    logic [tgpm_pkg::QCNT_W-1:0]       r_cnt, n_cnt;
    logic                              r_done, n_done;
    logic signed [tgpm_pkg::MUL_A_W+tgpm_pkg::MUL_B_W-1:0] prod;
    logic                              fits;

    assign prod = i_req.a * i_req.b;
    assign fits = {16'b0, r_rem} >= r_sd;

    always_comb begin
        n_res  = r_res;
        n_rem  = r_rem;
        n_sd   = r_sd;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            if (i_req.op == tgpm_pkg::ALU_MUL) begin
                n_res  = prod[63:0];
                n_done = 1'b1;
            end else begin
                n_rem = i_req.num;
                n_sd  = {16'b0, i_req.den} << (i_req.qbits - 5'd1);
                n_cnt = i_req.qbits;
                n_res = '0;
            end
        end else if (r_cnt != '0) begin
            if (fits) begin
                n_rem = r_rem - r_sd[63:0];
            end
            n_res  = {r_res[62:0], fits};
            n_sd   = r_sd >> 1;
            n_cnt  = r_cnt - 5'd1;
            n_done = (r_cnt == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_res <= n_res;
        r_rem <= n_rem;
        r_sd  <= n_sd;
    end

    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

// File: src/tgpm_exp.sv
// Exponential from a base-2 log argument: table lookup of the fraction and
// a shift by the integer part. Uses tgpm_pkg for the table.
module tgpm_exp (
    input  logic signed [63:0] i_prod,
    output logic [31:0]        o_val
);

    logic signed [47:0]              z;
    logic [47:0]                     zz;
    logic [6:0]                      n_biased;
    logic [6:0]                      lsh;
    logic [6:0]                      rsh;
    logic [31:0]                     idx_full;
    logic [tgpm_pkg::EXP_IDX_W-1:0]  idx;
    logic [tgpm_pkg::EXP_ROM_W-1:0]  t;

    always_comb begin
        z        = i_prod[63:16];
        zz       = z + 48'h400000;
        n_biased = zz[22:16];
        idx_full = 32'(zz[15:0]) * 32'(tgpm_pkg::EXP_TABLE_DEPTH);
        idx      = idx_full[16 +: tgpm_pkg::EXP_IDX_W];
        t        = tgpm_pkg::EXP_ROM[idx];
        lsh      = n_biased - 7'd64;
        rsh      = 7'd64 - n_biased;
        if (n_biased >= 7'd64) begin
            o_val = 32'(t) << lsh[3:0];
        end else begin
            o_val = 32'(t) >> rsh;
        end
    end

endmodule
